// ===== design/krt_pkg.sv =====
`timescale 1ns / 1ps

package krt_pkg;

  // Field widths of the item channels.
  localparam int unsigned CmdW    = 2;
  localparam int unsigned KeyW    = 64;
  localparam int unsigned HandleW = 16;
  localparam int unsigned StatusW = 2;
  localparam int unsigned UsedW   = 5;

  // Default table capacity.
  localparam int unsigned MaxEntriesDefault = 16;

  // Command codes.
  typedef enum logic [CmdW-1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_REMOVE = 2'd2
  } cmd_e;

  // Result status codes.
  typedef enum logic [StatusW-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_DUPLICATE = 2'd3
  } status_e;

  // One table slot: the key with its client handle.
  typedef struct packed {
    logic [KeyW-1:0]    key;
    logic [HandleW-1:0] handle;
  } entry_t;

endpackage

// ===== design/keyed_registration_table_unit.sv =====
`timescale 1ns / 1ps

// Keyed registration table: holds up to MAX_ENTRIES unique 64-bit keys, each
// with a 16-bit client handle, packed densely from slot 0 in a table memory
// with one write port and one registered read port. Every accepted item
// carries one command (lookup, insert or remove) and produces exactly one
// result item with a status, the handle that was found or removed (zero
// otherwise) and the entry count after the command. Insert reports a full
// table before it checks for a duplicate key, and remove fills the freed slot
// with the last entry. The search runs through one 64-bit key comparator that
// visits the occupied slots one after another; each slot takes a memory read,
// then a compare of the registered read data. A full table on insert, an empty
// table on lookup or remove and the unused command skip the search. A remove
// that hits below the last slot then reads the last entry and writes it into
// the freed slot, an insert of a new key appends it, and the result waits in
// the result register until it is taken. The input stall is high from
// acceptance until the result item has been taken. Reset empties the table at
// once; no clearing pass is needed because only slots below the entry count are ever used.
module keyed_registration_table_unit
  import krt_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = MaxEntriesDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Request channel.
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [CmdW-1:0]    command_i,
  input  logic [KeyW-1:0]    key_i,
  input  logic [HandleW-1:0] handle_i,
  // Result channel.
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [StatusW-1:0] status_o,
  output logic [HandleW-1:0] found_handle_o,
  output logic [UsedW-1:0]   entries_used_o
);

  // Slot index and count widths follow from the capacity.
  localparam int unsigned IdxW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CntW = $clog2(MAX_ENTRIES + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_ENTRIES);

  // Sequencer states.
  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_READ    = 3'd1;
  localparam logic [2:0] S_CMP     = 3'd2;
  localparam logic [2:0] S_MOVE_RD = 3'd3;
  localparam logic [2:0] S_MOVE_WR = 3'd4;
  localparam logic [2:0] S_APPEND  = 3'd5;
  localparam logic [2:0] S_OUT     = 3'd6;

  logic [2:0]         state_q, state_d;
  logic [CntW-1:0]    count_q, count_d;
  logic [IdxW-1:0]    idx_q, idx_d;
  logic [CmdW-1:0]    cmd_q, cmd_d;
  logic [KeyW-1:0]    key_q, key_d;
  logic [HandleW-1:0] handle_q, handle_d;
  logic [StatusW-1:0] status_q, status_d;
  logic [HandleW-1:0] found_q, found_d;

  // Table memory: one write port and one registered read port.
  entry_t          mem_q [MAX_ENTRIES];
  entry_t          rd_data_q;
  logic [IdxW-1:0] rd_addr;
  logic            wr_en;
  logic [IdxW-1:0] wr_addr;
  entry_t          wr_data;

  logic            in_accept;
  logic [CntW-1:0] last_slot;
  logic            at_last;
  logic            key_hit;

  assign in_accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);

  // Slot of the last occupied entry; only meaningful while the table is not empty.
  assign last_slot = count_q - CntW'(1);
  assign at_last   = (CntW'(idx_q) == last_slot);

  // The one shared comparator: stored key of the slot just read against the request.
  assign key_hit = (rd_data_q.key == key_q);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    idx_d    = idx_q;
    cmd_d    = cmd_q;
    key_d    = key_q;
    handle_d = handle_q;
    status_d = status_q;
    found_d  = found_q;
    rd_addr  = idx_q;
    wr_en    = 1'b0;
    wr_addr  = idx_q;
    wr_data  = '{key: key_q, handle: handle_q};

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          cmd_d    = command_i;
          key_d    = key_i;
          handle_d = handle_i;
          idx_d    = '0;
          status_d = ST_NOT_FOUND;
          found_d  = '0;
          if (command_i == CMD_INSERT && count_q >= CntMax) begin
            // A full table is reported before any duplicate check.
            status_d = ST_FULL;
            state_d  = S_OUT;
          end else if (command_i != CMD_LOOKUP && command_i != CMD_INSERT &&
                       command_i != CMD_REMOVE) begin
            // The unused command changes nothing and answers not found.
            state_d = S_OUT;
          end else if (count_q == '0) begin
            state_d = (command_i == CMD_INSERT) ? S_APPEND : S_OUT;
          end else begin
            state_d = S_READ;
          end
        end
      end

      S_READ: begin
        rd_addr = idx_q;
        state_d = S_CMP;
      end

      S_CMP: begin
        if (key_hit) begin
          unique case (cmd_q)
            CMD_LOOKUP: begin
              status_d = ST_OK;
              found_d  = rd_data_q.handle;
              state_d  = S_OUT;
            end
            CMD_INSERT: begin
              status_d = ST_DUPLICATE;
              state_d  = S_OUT;
            end
            default: begin
              // Remove: the handle goes out, the hole is filled by the last entry.
              status_d = ST_OK;
              found_d  = rd_data_q.handle;
              if (at_last) begin
                count_d = last_slot;
                state_d = S_OUT;
              end else begin
                state_d = S_MOVE_RD;
              end
            end
          endcase
        end else if (at_last) begin
          state_d = (cmd_q == CMD_INSERT) ? S_APPEND : S_OUT;
        end else begin
          idx_d   = idx_q + IdxW'(1);
          state_d = S_READ;
        end
      end

      S_MOVE_RD: begin
        rd_addr = last_slot[IdxW-1:0];
        state_d = S_MOVE_WR;
      end

      S_MOVE_WR: begin
        wr_en   = 1'b1;
        wr_addr = idx_q;
        wr_data = rd_data_q;
        count_d = last_slot;
        state_d = S_OUT;
      end

      S_APPEND: begin
        wr_en    = 1'b1;
        wr_addr  = count_q[IdxW-1:0];
        count_d  = count_q + CntW'(1);
        status_d = ST_OK;
        state_d  = S_OUT;
      end

      S_OUT: begin
        if (!out_stall_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    cmd_q    <= cmd_d;
    key_q    <= key_d;
    handle_q <= handle_d;
    status_q <= status_d;
    found_q  <= found_d;
  end

  assign out_valid_o    = (state_q == S_OUT);
  assign status_o       = status_q;
  assign found_handle_o = found_q;
  assign entries_used_o = UsedW'(count_q);

endmodule

// ===== sim/keyed_registration_table_unit_tb.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the keyed registration table. A queue of requests is
// built up front: a short directed sweep of the corner cases, then phases of
// random traffic over a small key pool, so that hits, duplicates and full
// table answers are common. The driver feeds the queue to the request channel
// in bursts with random gaps. The monitor predicts one result for every
// request it sees accepted and checks every accepted result against the
// oldest prediction. The receiver stalls in segments of varying density and
// holds off once for a long stretch.
module keyed_registration_table_unit_tb;
  import krt_pkg::*;

  localparam int unsigned MAX_ENTRIES = MaxEntriesDefault;
  localparam int unsigned KEY_POOL = 20;
  localparam int unsigned PHASES = 13;
  localparam int unsigned PHASE_ITEMS = 100;
  localparam int unsigned HOLDOFF_AT = 400;
  localparam int unsigned HOLDOFF_CYCLES = 400;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned TAIL_CYCLES = 2 * MAX_ENTRIES + 8;

  // The one command code that the package leaves undefined.
  localparam logic [CmdW-1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    logic [CmdW-1:0]    cmd;
    logic [KeyW-1:0]    key;
    logic [HandleW-1:0] handle;
    bit                 drain;  // hold this request until all results are in
  } table_req_t;

  typedef struct {
    status_e            status;
    logic [HandleW-1:0] found;
    logic [UsedW-1:0]   used;
  } table_reply_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [CmdW-1:0]    command_i = '0;
  logic [KeyW-1:0]    key_i = '0;
  logic [HandleW-1:0] handle_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [StatusW-1:0] status_o;
  logic [HandleW-1:0] found_handle_o;
  logic [UsedW-1:0]   entries_used_o;

  keyed_registration_table_unit #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .command_i     (command_i),
    .key_i         (key_i),
    .handle_i      (handle_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .found_handle_o(found_handle_o),
    .entries_used_o(entries_used_o)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // Shadow copy of the table, densely packed from slot 0.
  logic [KeyW-1:0]    shadow_keys[MAX_ENTRIES];
  logic [HandleW-1:0] shadow_handles[MAX_ENTRIES];
  int unsigned        shadow_count = 0;

  table_req_t   pending_reqs[$];
  table_reply_t expected_replies[$];
  table_req_t   cur_req;
  int unsigned  reqs_offered = 0;
  int unsigned  reqs_taken = 0;
  int unsigned  mismatches = 0;
  int unsigned  quiet_cycles = 0;

  // Applies one command to the shadow table and returns the answer it gives.
  function automatic table_reply_t predict_reply(logic [CmdW-1:0] cmd,
                                                 logic [KeyW-1:0] key,
                                                 logic [HandleW-1:0] hnd);
    table_reply_t r;
    int slot;
    r.status = ST_NOT_FOUND;
    r.found = '0;
    slot = -1;
    for (int i = 0; i < int'(shadow_count); i++) begin
      if (slot < 0 && shadow_keys[i] == key) slot = i;
    end
    case (cmd)
      CMD_LOOKUP: begin
        if (slot >= 0) begin
          r.status = ST_OK;
          r.found = shadow_handles[slot];
        end
      end
      CMD_INSERT: begin
        // A full table is reported even when the key is already present.
        if (shadow_count >= MAX_ENTRIES) begin
          r.status = ST_FULL;
        end else if (slot >= 0) begin
          r.status = ST_DUPLICATE;
        end else begin
          shadow_keys[shadow_count] = key;
          shadow_handles[shadow_count] = hnd;
          shadow_count++;
          r.status = ST_OK;
        end
      end
      CMD_REMOVE: begin
        if (slot >= 0) begin
          r.found = shadow_handles[slot];
          shadow_count--;
          shadow_keys[slot] = shadow_keys[shadow_count];
          shadow_handles[slot] = shadow_handles[shadow_count];
          r.status = ST_OK;
        end
      end
      default: begin
      end
    endcase
    r.used = UsedW'(shadow_count);
    return r;
  endfunction

  task automatic queue_req(logic [CmdW-1:0] cmd, logic [KeyW-1:0] key,
                           logic [HandleW-1:0] hnd, bit drain);
    table_req_t req;
    req.cmd = cmd;
    req.key = key;
    req.handle = hnd;
    req.drain = drain;
    pending_reqs.push_back(req);
  endtask

  task automatic note_mismatch(string what);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", what);
  endtask

  // Driver: offers the next queued request at the falling edge and holds it
  // until the monitor has seen it accepted.
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  always @(negedge clk_i) begin
    table_req_t item;
    logic drive_valid;
    item = cur_req;
    drive_valid = in_valid_i;
    if (!rst_ni) begin
      drive_valid = 1'b0;
    end else begin
      if (in_valid_i && reqs_taken == reqs_offered) drive_valid = 1'b0;
      if (!drive_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_reqs.size() > 0 &&
                     !(pending_reqs[0].drain && expected_replies.size() > 0)) begin
          item = pending_reqs.pop_front();
          drive_valid = 1'b1;
          reqs_offered++;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 30);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
      end
    end
    cur_req = item;
    in_valid_i <= drive_valid;
    command_i <= item.cmd;
    key_i <= item.key;
    handle_i <= item.handle;
  end

  // Receiver: segments of no, light or heavy stalling, plus one long hold-off
  // that leaves the block stalled on its input with a request waiting.
  int unsigned seg_left = 0;
  int unsigned seg_mode = 0;
  int unsigned holdoff_left = 0;
  bit          holdoff_done = 1'b0;

  always @(negedge clk_i) begin
    logic stall;
    if (seg_left == 0) begin
      seg_mode = $urandom_range(0, 2);
      seg_left = $urandom_range(10, 150);
    end else begin
      seg_left--;
    end
    case (seg_mode)
      0: stall = 1'b0;
      1: stall = ($urandom_range(0, 1) == 0);
      default: stall = ($urandom_range(0, 3) != 0);
    endcase
    if (!holdoff_done && reqs_taken >= HOLDOFF_AT) begin
      holdoff_done = 1'b1;
      holdoff_left = HOLDOFF_CYCLES;
    end
    if (holdoff_left > 0) begin
      holdoff_left--;
      stall = 1'b1;
    end
    out_stall_i <= stall;
  end

  // Monitor: results are checked before the request of the same edge is
  // predicted, so a result can never match its own request early.
  always @(posedge clk_i) begin
    table_reply_t want;
    bit moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        moved = 1'b1;
        if (expected_replies.size() == 0) begin
          note_mismatch($sformatf("unexpected result status=%0d handle=%h used=%0d",
                                  status_o, found_handle_o, entries_used_o));
        end else begin
          want = expected_replies.pop_front();
          if (status_o !== want.status || found_handle_o !== want.found ||
              entries_used_o !== want.used) begin
            note_mismatch($sformatf(
                "status %0d/%0d handle %h/%h used %0d/%0d (expected/actual)",
                want.status, status_o, want.found, found_handle_o,
                want.used, entries_used_o));
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        moved = 1'b1;
        expected_replies.push_back(predict_reply(command_i, key_i, handle_i));
        reqs_taken++;
      end
    end
    if (moved) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    logic [KeyW-1:0] fill_keys[MAX_ENTRIES - 2];
    logic [KeyW-1:0] pool[KEY_POOL];
    logic [KeyW-1:0] key;
    logic [CmdW-1:0] cmd;
    int unsigned pick;
    int unsigned ins_share;
    int unsigned rem_share;

    // Directed sweep: empty table, both key extremes, a duplicate, filling to
    // capacity, full before duplicate, removal from the last and first slots.
    queue_req(CMD_LOOKUP, '0, 16'hFFFF, 1'b0);
    queue_req(CMD_REMOVE, '1, 16'hFFFF, 1'b0);
    queue_req(CMD_UNUSED, '0, '0, 1'b0);
    queue_req(CMD_INSERT, '0, '0, 1'b0);
    queue_req(CMD_INSERT, '1, 16'hFFFF, 1'b0);
    queue_req(CMD_INSERT, '0, 16'h1234, 1'b0);
    queue_req(CMD_LOOKUP, '1, '0, 1'b0);
    queue_req(CMD_LOOKUP, '0, 16'hFFFF, 1'b0);
    for (int i = 0; i < int'(MAX_ENTRIES) - 2; i++) begin
      fill_keys[i] = {$urandom, $urandom};
      queue_req(CMD_INSERT, fill_keys[i], HandleW'($urandom_range(0, 65535)), 1'b0);
    end
    queue_req(CMD_INSERT, {$urandom, $urandom}, HandleW'($urandom_range(0, 65535)),
              1'b0);
    queue_req(CMD_INSERT, '0, '0, 1'b0);
    queue_req(CMD_REMOVE, fill_keys[MAX_ENTRIES - 3], '0, 1'b0);
    queue_req(CMD_REMOVE, '0, '0, 1'b0);
    queue_req(CMD_LOOKUP, fill_keys[MAX_ENTRIES - 4], '0, 1'b0);
    queue_req(CMD_UNUSED, '1, 16'hFFFF, 1'b0);

    // Random phases alternate between insert-heavy and remove-heavy mixes so
    // the table keeps swinging between empty and full. Each phase starts with
    // a pause until every outstanding result has arrived.
    for (int p = 0; p < int'(PHASES); p++) begin
      for (int k = 0; k < int'(KEY_POOL); k++) begin
        if (k > 0 && $urandom_range(0, 3) == 0) begin
          pool[k] = pool[$urandom_range(0, k - 1)] ^ (64'd1 << $urandom_range(0, 63));
        end else begin
          pool[k] = {$urandom, $urandom};
        end
      end
      if (p % 4 == 1) pool[0] = '0;
      if (p % 4 == 3) pool[1] = '1;
      ins_share = (p % 2 == 0) ? 55 : 25;
      rem_share = (p % 2 == 0) ? 15 : 40;
      for (int n = 0; n < int'(PHASE_ITEMS); n++) begin
        pick = $urandom_range(0, 99);
        if (pick < ins_share) cmd = CMD_INSERT;
        else if (pick < ins_share + rem_share) cmd = CMD_REMOVE;
        else if (pick < 95) cmd = CMD_LOOKUP;
        else cmd = CMD_UNUSED;
        if ($urandom_range(0, 9) == 0) key = {$urandom, $urandom};
        else key = pool[$urandom_range(0, KEY_POOL - 1)];
        queue_req(cmd, key, HandleW'($urandom_range(0, 65535)), n == 0);
      end
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_reqs.size() > 0 || reqs_taken != reqs_offered ||
           expected_replies.size() > 0) begin
      @(posedge clk_i);
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && expected_replies.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
